// ===== src/broadcast_elementwise_alu_unit_macros.svh =====
// Assertion macros for the broadcast elementwise ALU unit.
`ifndef BROADCAST_ELEMENTWISE_ALU_UNIT_MACROS_SVH
`define BROADCAST_ELEMENTWISE_ALU_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define BEAU_ASSERT_IMPLY(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("assertion failed");
`define BEAU_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("assertion failed");
`define BEAU_ASSERT_DELAY(lbl, ck, rn, a, n, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> ##n (c)) \
		else $error("assertion failed");
`else
`define BEAU_ASSERT_IMPLY(lbl, ck, rn, a, c)
`define BEAU_ASSERT_NEXT(lbl, ck, rn, a, c)
`define BEAU_ASSERT_DELAY(lbl, ck, rn, a, n, c)
`endif
`endif

// ===== src/bea_pkg.sv =====
// Shared types, constants and arithmetic helpers of the broadcast ALU.
package bea_pkg;
	localparam int MAX_DIMS = 4;
	localparam int DEPTH = 1024;
	localparam int RANK_CAP = (MAX_DIMS < 4) ? MAX_DIMS : 4;
	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH + 1);
	localparam int IW = 16;
	localparam int VW = 32;
	localparam int DIV_BITS = 4;
	localparam int DIM_DSTG = IW / DIV_BITS;
	localparam int DIM_STG = DIM_DSTG + 1;
	localparam int ALU_DSTG = VW / DIV_BITS;
	localparam int PIPE_LAT = DIM_STG * RANK_CAP + ALU_DSTG + 4;
	localparam int CFG_W = 64;
	localparam int CFG_IW = 3;
	localparam int RANK_W = 3;

	typedef enum logic [1:0] {
		OP_LOAD_A  = 2'd0,
		OP_LOAD_B  = 2'd1,
		OP_COMPUTE = 2'd2
	} op_e;

	typedef enum logic [2:0] {
		ALU_ADD = 3'd0,
		ALU_SUB = 3'd1,
		ALU_MUL = 3'd2,
		ALU_MAX = 3'd3,
		ALU_DIV = 3'd4,
		ALU_GT  = 3'd5
	} alu_e;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ALU_OP    = 3'd0,
		CFG_OUT_SHAPE = 3'd1,
		CFG_A_SHAPE   = 3'd2,
		CFG_B_SHAPE   = 3'd3,
		CFG_OUT_RANK  = 3'd4,
		CFG_A_RANK    = 3'd5,
		CFG_B_RANK    = 3'd6
	} cfg_e;

	typedef struct packed {
		logic [1:0]           operation;
		logic [IW-1:0]        element_index;
		logic signed [VW-1:0] load_value;
	} in_t;

	typedef struct packed {
		logic signed [VW-1:0] result_value;
		logic [IW-1:0]        out_index;
	} out_t;

	typedef struct packed {
		logic          vld;
		logic [1:0]    op;
		logic [IW-1:0] idx;
		logic [VW-1:0] val;
		logic [IW-1:0] rest;
		logic [IW-1:0] rem;
		logic [SW-1:0] acc_a;
		logic [SW-1:0] acc_b;
		logic [SW-1:0] str_a;
		logic [SW-1:0] str_b;
	} ix_t;

	typedef struct packed {
		logic [IW-1:0] oext;
		logic [IW-1:0] a_ext;
		logic [IW-1:0] b_ext;
		logic          a_act;
		logic          b_act;
	} dim_cfg_t;

	typedef struct packed {
		logic                 vld;
		logic [IW-1:0]        idx;
		logic signed [VW-1:0] a;
		logic signed [VW-1:0] b;
	} alu_in_t;

	typedef struct packed {
		logic          vld;
		logic [IW-1:0] idx;
		logic [VW-1:0] simple;
		logic          neg;
		logic          bz;
		logic [VW-1:0] rem;
		logic [VW-1:0] n;
		logic [VW-1:0] d;
	} dv_t;

	typedef struct packed {
		logic [IW-1:0] rem;
		logic [IW-1:0] n;
	} ixdv_t;

	typedef struct packed {
		logic [VW-1:0] rem;
		logic [VW-1:0] n;
	} vdv_t;

	function automatic ixdv_t ix_div_step(logic [IW-1:0] rem, logic [IW-1:0] n,
			logic [IW-1:0] d);
		logic [IW:0] r;
		logic [IW-1:0] rr;
		logic [IW-1:0] nn;
		ixdv_t o;
		rr = rem;
		nn = n;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {rr, nn[IW-1]};
			nn = {nn[IW-2:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				nn[0] = 1'b1;
			end
			rr = r[IW-1:0];
		end
		o.rem = rr;
		o.n = nn;
		return o;
	endfunction

	function automatic vdv_t v_div_step(logic [VW-1:0] rem, logic [VW-1:0] n,
			logic [VW-1:0] d);
		logic [VW:0] r;
		logic [VW-1:0] rr;
		logic [VW-1:0] nn;
		vdv_t o;
		rr = rem;
		nn = n;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {rr, nn[VW-1]};
			nn = {nn[VW-2:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				nn[0] = 1'b1;
			end
			rr = r[VW-1:0];
		end
		o.rem = rr;
		o.n = nn;
		return o;
	endfunction

	// acc + str * c, saturated at DEPTH (anything at DEPTH is out of range)
	function automatic logic [SW-1:0] sat_mac(logic [SW-1:0] acc, logic [SW-1:0] str,
			logic [IW-1:0] c);
		logic [SW+IW:0] s;
		s = (SW+IW+1)'(acc) + (SW+IW+1)'(str) * (SW+IW+1)'(c);
		return (s > (SW+IW+1)'(DEPTH)) ? SW'(DEPTH) : s[SW-1:0];
	endfunction

	function automatic logic [RANK_W-1:0] clamp_rank(logic [RANK_W-1:0] r,
			logic [RANK_W-1:0] hi);
		if (r < RANK_W'(1)) return RANK_W'(1);
		if (r > hi) return hi;
		return r;
	endfunction
endpackage

// ===== src/bea_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bea_ram #(
	parameter int DATA_W = 32,
	parameter int NUM_WORDS = 1024
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(NUM_WORDS)-1:0] waddr,
	input  logic [DATA_W-1:0]            wdata,
	input  logic [$clog2(NUM_WORDS)-1:0] raddr,
	output logic [DATA_W-1:0]            rdata
);
	logic [DATA_W-1:0] mem [NUM_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== src/bea_dim.sv =====
// One output dimension: pipelined digit split of the index and operand index update.
module bea_dim import bea_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ix_t      din,
	input  dim_cfg_t cfg,
	output ix_t      dout
);
	ix_t div_s [DIM_DSTG];
	ix_t acc_s;
	ix_t acc_d;
	ix_t last;

	for (genvar k = 0; k < DIM_DSTG; k++) begin : g_div
		ix_t src;
		ix_t nxt;
		ixdv_t st;
		if (k == 0) begin : g_first
			assign src = din;
		end else begin : g_next
			assign src = div_s[k-1];
		end
		assign st = ix_div_step(src.rem, src.rest, cfg.oext);
		always_comb begin
			nxt = src;
			nxt.rem = st.rem;
			nxt.rest = st.n;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[k].vld <= 1'b0;
			end else begin
				div_s[k] <= nxt;
			end
		end
	end

	assign last = div_s[DIM_DSTG-1];

	// rem is this dimension's coordinate, rest the index passed on
	always_comb begin
		acc_d = last;
		acc_d.rem = '0;
		if (cfg.a_act) begin
			if (last.rem < cfg.a_ext) begin
				acc_d.acc_a = sat_mac(last.acc_a, last.str_a, last.rem);
			end
			acc_d.str_a = sat_mac('0, last.str_a, cfg.a_ext);
		end
		if (cfg.b_act) begin
			if (last.rem < cfg.b_ext) begin
				acc_d.acc_b = sat_mac(last.acc_b, last.str_b, last.rem);
			end
			acc_d.str_b = sat_mac('0, last.str_b, cfg.b_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s.vld <= 1'b0;
		end else begin
			acc_s <= acc_d;
		end
	end

	assign dout = acc_s;
endmodule

// ===== src/bea_alu.sv =====
// Pipelined ALU: add, sub, mul, max, greater, and a radix-16 signed divider.
`include "broadcast_elementwise_alu_unit_macros.svh"
module bea_alu import bea_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  alu_in_t opnd,
	input  alu_e    op_cfg,
	output logic    done,
	output out_t    result
);
	dv_t e1_d;
	dv_t e1_s;
	dv_t dv_s [ALU_DSTG];
	logic [VW-1:0] prod;
	logic [VW-1:0] q;
	logic [VW-1:0] res_d;
	logic done_q;
	out_t res_q;

	assign prod = opnd.a * opnd.b;

	always_comb begin
		e1_d.vld = opnd.vld;
		e1_d.idx = opnd.idx;
		case (op_cfg)
			ALU_ADD: e1_d.simple = opnd.a + opnd.b;
			ALU_SUB: e1_d.simple = opnd.a - opnd.b;
			ALU_MUL: e1_d.simple = prod;
			ALU_MAX: e1_d.simple = (opnd.a > opnd.b) ? opnd.a : opnd.b;
			ALU_GT:  e1_d.simple = {{(VW-1){1'b0}}, opnd.a > opnd.b};
			default: e1_d.simple = '0;
		endcase
		e1_d.neg = opnd.a[VW-1] ^ opnd.b[VW-1];
		e1_d.bz = (opnd.b == '0);
		e1_d.rem = '0;
		e1_d.n = opnd.a[VW-1] ? VW'(-opnd.a) : opnd.a;
		e1_d.d = opnd.b[VW-1] ? VW'(-opnd.b) : opnd.b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e1_s.vld <= 1'b0;
		end else begin
			e1_s <= e1_d;
		end
	end

	for (genvar k = 0; k < ALU_DSTG; k++) begin : g_div
		dv_t src;
		dv_t nxt;
		vdv_t st;
		if (k == 0) begin : g_first
			assign src = e1_s;
		end else begin : g_next
			assign src = dv_s[k-1];
		end
		assign st = v_div_step(src.rem, src.n, src.d);
		always_comb begin
			nxt = src;
			nxt.rem = st.rem;
			nxt.n = st.n;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k].vld <= 1'b0;
			end else begin
				dv_s[k] <= nxt;
			end
		end
	end

	assign q = dv_s[ALU_DSTG-1].n;

	always_comb begin
		if (op_cfg == ALU_DIV) begin
			if (dv_s[ALU_DSTG-1].bz) begin
				res_d = '0;
			end else begin
				res_d = dv_s[ALU_DSTG-1].neg ? VW'(-q) : q;
			end
		end else begin
			res_d = dv_s[ALU_DSTG-1].simple;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_s[ALU_DSTG-1].vld;
		end
	end

	always_ff @(posedge clk) begin
		res_q.result_value <= res_d;
		res_q.out_index <= dv_s[ALU_DSTG-1].idx;
	end

	assign done = done_q;
	assign result = res_q;

	`BEAU_ASSERT_IMPLY(a_gt_bool, clk, arst_n, done && op_cfg == ALU_GT,
		result.result_value[VW-1:1] == '0)
	`BEAU_ASSERT_NEXT(a_div_zero, clk, arst_n,
		dv_s[ALU_DSTG-1].vld && dv_s[ALU_DSTG-1].bz && op_cfg == ALU_DIV,
		result.result_value == '0)
endmodule

// ===== src/broadcast_elementwise_alu_unit.sv =====
// Top level of the broadcast elementwise ALU: config, index pipeline, stores, ALU.
//
// channel  | handshake            | word
// ---------+----------------------+---------------------------------------
// command  | start, busy          | cmd: operation, element_index, load_value
// result   | done (one cycle)     | result: result_value, out_index
// config   | cfg_we               | cfg_idx, cfg_wdata
//
// One word per cycle; busy never rises. A compute word passes the input
// register, four radix-16 stages and one stride stage per dimension, the
// store read, the ALU entry register, the eight-stage divider and the result
// register. Loads write the stores at the read stage, so words stay in order.
// No clearing pass after reset; the receiver cannot stall.
`include "broadcast_elementwise_alu_unit_macros.svh"
module broadcast_elementwise_alu_unit import bea_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  in_t               cmd,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output logic              done,
	output out_t              result
);
	localparam logic [CFG_W-1:0] SHAPE_RST = 64'h0001_0001_0001_0001;

	alu_e alu_op_q;
	logic [CFG_W-1:0] out_shape_q;
	logic [CFG_W-1:0] a_shape_q;
	logic [CFG_W-1:0] b_shape_q;
	logic [RANK_W-1:0] out_rank_q;
	logic [RANK_W-1:0] a_rank_q;
	logic [RANK_W-1:0] b_rank_q;
	logic [RANK_W-1:0] orank;
	logic [RANK_W-1:0] ar;
	logic [RANK_W-1:0] br;
	logic cmd_acc;
	logic cmp_acc;
	ix_t in_s;
	ix_t ch [RANK_CAP+1];
	dim_cfg_t dc [RANK_CAP];
	ix_t last;
	logic we_a;
	logic we_b;
	logic [VW-1:0] rd_a;
	logic [VW-1:0] rd_b;
	logic mem_vld_s;
	logic [IW-1:0] mem_idx_s;
	logic a_ok_s;
	logic b_ok_s;
	alu_in_t alu_in;

	assign busy = 1'b0;
	assign cmd_acc = start && !busy;
	assign cmp_acc = cmd_acc && cmd.operation == OP_COMPUTE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alu_op_q <= ALU_ADD;
			out_shape_q <= SHAPE_RST;
			a_shape_q <= SHAPE_RST;
			b_shape_q <= SHAPE_RST;
			out_rank_q <= RANK_W'(1);
			a_rank_q <= RANK_W'(1);
			b_rank_q <= RANK_W'(1);
		end else if (cfg_we) begin
			case (cfg_e'(cfg_idx))
				CFG_ALU_OP:    alu_op_q <= alu_e'(cfg_wdata[2:0]);
				CFG_OUT_SHAPE: out_shape_q <= cfg_wdata;
				CFG_A_SHAPE:   a_shape_q <= cfg_wdata;
				CFG_B_SHAPE:   b_shape_q <= cfg_wdata;
				CFG_OUT_RANK:  out_rank_q <= cfg_wdata[RANK_W-1:0];
				CFG_A_RANK:    a_rank_q <= cfg_wdata[RANK_W-1:0];
				CFG_B_RANK:    b_rank_q <= cfg_wdata[RANK_W-1:0];
				default: ;
			endcase
		end
	end

	assign orank = clamp_rank(out_rank_q, RANK_W'(RANK_CAP));
	assign ar = clamp_rank(a_rank_q, orank);
	assign br = clamp_rank(b_rank_q, orank);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s.vld <= 1'b0;
		end else begin
			in_s.vld <= cmd_acc;
			in_s.op <= cmd.operation;
			in_s.idx <= cmd.element_index;
			in_s.val <= cmd.load_value;
			in_s.rest <= cmd.element_index;
			in_s.rem <= '0;
			in_s.acc_a <= '0;
			in_s.acc_b <= '0;
			in_s.str_a <= SW'(1);
			in_s.str_b <= SW'(1);
		end
	end

	assign ch[0] = in_s;

	for (genvar d = 0; d < RANK_CAP; d++) begin : g_dim
		logic [IW-1:0] oext;
		assign oext = out_shape_q[IW*d +: IW];
		assign dc[d].oext = (oext == '0) ? IW'(1) : oext;
		assign dc[d].a_ext = a_shape_q[IW*d +: IW];
		assign dc[d].b_ext = b_shape_q[IW*d +: IW];
		assign dc[d].a_act = RANK_W'(d) < ar;
		assign dc[d].b_act = RANK_W'(d) < br;
		bea_dim u_dim (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (ch[d]),
			.cfg    (dc[d]),
			.dout   (ch[d+1])
		);
	end

	assign last = ch[RANK_CAP];
	assign we_a = last.vld && last.op == OP_LOAD_A && {1'b0, last.idx} < (IW+1)'(DEPTH);
	assign we_b = last.vld && last.op == OP_LOAD_B && {1'b0, last.idx} < (IW+1)'(DEPTH);

	bea_ram #(.DATA_W(VW), .NUM_WORDS(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (last.idx[AW-1:0]),
		.wdata (last.val),
		.raddr (last.acc_a[AW-1:0]),
		.rdata (rd_a)
	);

	bea_ram #(.DATA_W(VW), .NUM_WORDS(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (last.idx[AW-1:0]),
		.wdata (last.val),
		.raddr (last.acc_b[AW-1:0]),
		.rdata (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_s <= 1'b0;
		end else begin
			mem_vld_s <= last.vld && last.op == OP_COMPUTE;
		end
	end

	always_ff @(posedge clk) begin
		mem_idx_s <= last.idx;
		a_ok_s <= last.acc_a != SW'(DEPTH);
		b_ok_s <= last.acc_b != SW'(DEPTH);
	end

	assign alu_in.vld = mem_vld_s;
	assign alu_in.idx = mem_idx_s;
	assign alu_in.a = a_ok_s ? rd_a : '0;
	assign alu_in.b = b_ok_s ? rd_b : '0;

	bea_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.opnd   (alu_in),
		.op_cfg (alu_op_q),
		.done   (done),
		.result (result)
	);

	`BEAU_ASSERT_DELAY(a_cmp_done, clk, arst_n, cmp_acc, PIPE_LAT, done)
	`BEAU_ASSERT_IMPLY(a_done_src, clk, arst_n, done, $past(cmp_acc, PIPE_LAT))
endmodule
